// ===== hdl/mwsm_pkg.sv =====
// Shared types and constants for the multiword schoolbook multiplier.
// Used by the cell modules, the MAC, the top level and the checker.
// No dependencies.
package mwsm_pkg;

    localparam int WORD_CAP    = 16;   // product must fit 32 indexed words
    localparam int OPERAND_W   = 63;
    localparam int WBITS_W     = 6;
    localparam int MLEN_W      = 6;    // bit length of a 63-bit value
    localparam int OUT_INDEX_W = 5;
    localparam int OUT_VALUE_W = 32;
    localparam int S_TDATA_W   = 128;
    localparam int M_TDATA_W   = 40;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 63;
    localparam int W_MIN       = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_WORD_BITS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS   = 1'd1;

    localparam logic [WBITS_W-1:0]   WORD_BITS_RST = 6'd8;
    localparam logic [OPERAND_W-1:0] MODULUS_RST   = {OPERAND_W{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_LOAD    = 5'b00010,
        S_MAC     = 5'b00100,
        S_EMIT_HI = 5'b01000,
        S_EMIT_LO = 5'b10000
    } mwsm_state_t;

    // control broadcast to every product cell
    typedef struct packed {
        logic load;   // shift operand words in, clear product
        logic mac;    // one multiply-accumulate step
        logic last;   // last step of a row
        logic shr;    // shift product window toward the tail
    } mwsm_cell_ctl_t;

    typedef struct packed {
        logic push;
        logic pop;
    } mwsm_stack_ctl_t;

    function automatic logic [MLEN_W-1:0] bit_length(input logic [OPERAND_W-1:0] x);
        logic [MLEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < OPERAND_W; i++)
        begin
            if (x[i])
            begin
                n = MLEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== hdl/multiword_schoolbook_multiplier_core.sv =====
// Multiword schoolbook multiplier. Each input item carries two 63-bit
// operands; the block splits both into t words of w bits (w from word_bits,
// clamped to 4..MAX_WORD_BITS; t = ceil(bitlen(modulus-1)/w), at least 1 and
// at most min(MAX_WORDS,16)) and returns 2t product words, most significant
// first, with tlast on word 0. Operand words are shifted into the row of
// cells from the top, the row feeds a single word MAC at its head one
// partial product per cycle, and results leave one word per cycle while
// the output is not stalled. The next item is taken once the last word
// sits in the output register.
// Depends on mwsm_pkg, mwsm_cell, mwsm_stack_cell and mwsm_mac.
module multiword_schoolbook_multiplier_core
    import mwsm_pkg::*;
#(
    parameter int MAX_WORDS     = 16,
    parameter int MAX_WORD_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // operand_a[62:0], operand_b[125:63]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // word_index[4:0], word_value[36:5]
    output logic                   m_tlast,   // last_word
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CELLS = (MAX_WORDS < WORD_CAP) ? MAX_WORDS : WORD_CAP;
    localparam int WW    = MAX_WORD_BITS;
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int IDX_W = $clog2(CELLS);
    localparam int OFF_W = $clog2((CELLS + 1) * MAX_WORD_BITS + 64);

    // configuration
    logic [WBITS_W-1:0]   word_bits_reg;
    logic [OPERAND_W-1:0] modulus_reg;

    // per-item setup
    mwsm_state_t          state_reg, state_next;
    logic [WBITS_W-1:0]   w_reg;
    logic [WW-1:0]        mask_reg;
    logic [MLEN_W-1:0]    m_reg;
    logic [OPERAND_W-1:0] a_sh_reg;
    logic [OPERAND_W-1:0] b_sh_reg;
    logic [OFF_W-1:0]     off_reg;
    logic [CNT_W-1:0]     t_reg;
    logic [IDX_W-1:0]     ld_reg;
    logic [CNT_W-1:0]     i_reg;
    logic [CNT_W-1:0]     j_reg;
    logic [WW-1:0]        carry_reg;
    logic [OUT_INDEX_W-1:0] e_reg;

    // output register
    logic                   m_tvalid_reg;
    logic [OUT_INDEX_W-1:0] o_index_reg;
    logic [OUT_VALUE_W-1:0] o_value_reg;
    logic                   o_last_reg;

    logic [WBITS_W-1:0] w_eff;
    logic [WW:0]        mask_wide;
    logic [MLEN_W-1:0]  m_in;
    logic               in_acc;
    logic               out_free;
    logic               emit;
    logic               last_step;
    logic [WW-1:0]      load_a;
    logic [WW-1:0]      load_b;
    logic [WW-1:0]      mac_low;
    logic [WW-1:0]      mac_carry;
    logic [IDX_W-1:0]   tail_sel;
    logic [WW-1:0]      emit_value;

    mwsm_cell_ctl_t  cell_ctl;
    mwsm_stack_ctl_t stk_ctl;

    logic [WW-1:0] a_q [CELLS];
    logic [WW-1:0] b_q [CELLS];
    logic [WW-1:0] p_q [CELLS];
    logic [WW-1:0] s_q [CELLS];
    logic [CELLS-1:0] is_tail;
    logic [CELLS-1:0] is_pre;

    // word width clamp, mask and bit length of modulus-1
    always_comb
    begin
        if (word_bits_reg < WBITS_W'(W_MIN))
        begin
            w_eff = WBITS_W'(W_MIN);
        end
        else if (word_bits_reg > WBITS_W'(MAX_WORD_BITS))
        begin
            w_eff = WBITS_W'(MAX_WORD_BITS);
        end
        else
        begin
            w_eff = word_bits_reg;
        end
        mask_wide = ((WW + 1)'(1) << w_eff) - (WW + 1)'(1);
        m_in = (modulus_reg == '0) ? '0 : bit_length(modulus_reg - OPERAND_W'(1));
    end

    assign s_tready  = state_reg[0];   // S_IDLE
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = (state_reg == S_EMIT_HI || state_reg == S_EMIT_LO) && out_free;
    assign last_step = (j_reg == t_reg - CNT_W'(1));
    assign load_a    = a_sh_reg[WW-1:0] & mask_reg;
    assign load_b    = b_sh_reg[WW-1:0] & mask_reg;
    assign tail_sel  = IDX_W'(t_reg - CNT_W'(1));
    assign emit_value = (state_reg == S_EMIT_HI) ? p_q[tail_sel] : s_q[0];

    always_comb
    begin
        cell_ctl.load = (state_reg == S_LOAD);
        cell_ctl.mac  = (state_reg == S_MAC);
        cell_ctl.last = last_step;
        cell_ctl.shr  = (state_reg == S_EMIT_HI) && out_free;
        stk_ctl.push  = (state_reg == S_MAC) && (j_reg == '0);
        stk_ctl.pop   = (state_reg == S_EMIT_LO) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (ld_reg == IDX_W'(CELLS - 1))
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (last_step && i_reg == t_reg - CNT_W'(1))
                begin
                    state_next = S_EMIT_HI;
                end
            end
            S_EMIT_HI:
            begin
                if (out_free && e_reg == OUT_INDEX_W'(t_reg))
                begin
                    state_next = S_EMIT_LO;
                end
            end
            S_EMIT_LO:
            begin
                if (out_free && e_reg == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            word_bits_reg <= WORD_BITS_RST;
            modulus_reg   <= MODULUS_RST;
            m_tvalid_reg  <= 1'b0;
            t_reg         <= CNT_W'(1);
            ld_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            e_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WORD_BITS: word_bits_reg <= cfg_data[WBITS_W-1:0];
                    REG_MODULUS:   modulus_reg   <= cfg_data[OPERAND_W-1:0];
                    default:       ;
                endcase
            end
            if (emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (in_acc)
            begin
                t_reg  <= CNT_W'(1);
                ld_reg <= '0;
            end
            if (state_reg == S_LOAD)
            begin
                ld_reg <= ld_reg + IDX_W'(1);
                if (off_reg < OFF_W'(m_reg))
                begin
                    t_reg <= CNT_W'(ld_reg) + CNT_W'(1);
                end
                i_reg <= '0;
                j_reg <= '0;
            end
            if (state_reg == S_MAC)
            begin
                if (last_step)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + CNT_W'(1);
                    e_reg <= OUT_INDEX_W'({t_reg, 1'b0} - (CNT_W + 1)'(1));
                end
                else
                begin
                    j_reg <= j_reg + CNT_W'(1);
                end
            end
            if (emit)
            begin
                e_reg <= e_reg - OUT_INDEX_W'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_sh_reg <= s_tdata[OPERAND_W-1:0];
            b_sh_reg <= s_tdata[2*OPERAND_W-1:OPERAND_W];
            w_reg    <= w_eff;
            mask_reg <= mask_wide[WW-1:0];
            m_reg    <= m_in;
            off_reg  <= '0;
        end
        if (state_reg == S_LOAD)
        begin
            // words past the top of the operand fall out as zeros
            a_sh_reg  <= a_sh_reg >> w_reg;
            b_sh_reg  <= b_sh_reg >> w_reg;
            off_reg   <= off_reg + OFF_W'(w_reg);
            carry_reg <= '0;
        end
        if (state_reg == S_MAC)
        begin
            carry_reg <= last_step ? '0 : mac_carry;
        end
        if (emit)
        begin
            o_index_reg <= e_reg;
            o_value_reg <= OUT_VALUE_W'(emit_value);
            o_last_reg  <= (e_reg == '0);
        end
    end

    mwsm_mac #(
        .WIDTH (WW)
    ) u_mac (
        .a         (a_q[0]),
        .b         (b_q[0]),
        .p         (p_q[0]),
        .carry_in  (carry_reg),
        .w         (w_reg),
        .mask      (mask_reg),
        .low       (mac_low),
        .carry_out (mac_carry)
    );

    genvar k;
    generate
        for (k = 0; k < CELLS; k++)
        begin : g_cell
            logic [WW-1:0] a_nb;
            logic [WW-1:0] b_nb;
            logic [WW-1:0] p_nb1;
            logic [WW-1:0] p_nb2;
            logic [WW-1:0] p_lo;
            logic [WW-1:0] s_up;
            logic [WW-1:0] s_dn;

            assign is_tail[k] = ((CNT_W + 1)'(k + 1) == {1'b0, t_reg});
            assign is_pre[k]  = ((CNT_W + 1)'(k + 2) == {1'b0, t_reg});

            if (k == CELLS - 1)
            begin : g_top
                assign a_nb  = load_a;
                assign b_nb  = cell_ctl.load ? load_b : b_q[0];
                assign p_nb1 = '0;
                assign s_dn  = '0;
            end
            else
            begin : g_mid
                assign a_nb  = a_q[k+1];
                assign b_nb  = b_q[k+1];
                assign p_nb1 = p_q[k+1];
                assign s_dn  = s_q[k+1];
            end

            if (k >= CELLS - 2)
            begin : g_top2
                assign p_nb2 = '0;
            end
            else
            begin : g_mid2
                assign p_nb2 = p_q[k+2];
            end

            if (k == 0)
            begin : g_bot
                assign p_lo = '0;
                assign s_up = mac_low;
            end
            else
            begin : g_up
                assign p_lo = p_q[k-1];
                assign s_up = s_q[k-1];
            end

            mwsm_cell #(
                .WIDTH (WW)
            ) u_cell (
                .clk     (clk),
                .ctl     (cell_ctl),
                .is_tail (is_tail[k]),
                .is_pre  (is_pre[k]),
                .a_nb    (a_nb),
                .b_nb    (b_nb),
                .b_head  (b_q[0]),
                .p_nb1   (p_nb1),
                .p_nb2   (p_nb2),
                .p_lo    (p_lo),
                .low     (mac_low),
                .carry   (mac_carry),
                .a_q     (a_q[k]),
                .b_q     (b_q[k]),
                .p_q     (p_q[k])
            );

            mwsm_stack_cell #(
                .WIDTH (WW)
            ) u_stk (
                .clk  (clk),
                .ctl  (stk_ctl),
                .d_up (s_up),
                .d_dn (s_dn),
                .q    (s_q[k])
            );
        end
    endgenerate

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, o_value_reg, o_index_reg};
    assign m_tlast  = o_last_reg;

endmodule

// ===== hdl/mwsm_mac.sv =====
// Word multiply-accumulate unit: p + a*b + carry, split at the word width.
// Depends on mwsm_pkg for the size of the word-width input.
// Purely combinational; sits at the head of the cell row.
module mwsm_mac
    import mwsm_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    input  logic [WIDTH-1:0]   p,
    input  logic [WIDTH-1:0]   carry_in,
    input  logic [WBITS_W-1:0] w,
    input  logic [WIDTH-1:0]   mask,
    output logic [WIDTH-1:0]   low,
    output logic [WIDTH-1:0]   carry_out
);

    logic [2*WIDTH-1:0] prod;
    logic [2*WIDTH-1:0] sum;
    logic [2*WIDTH-1:0] hi;

    // words are below 2^w, so the sum never exceeds 2^(2w)-1
    assign prod      = {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
    assign sum       = prod + {{WIDTH{1'b0}}, p} + {{WIDTH{1'b0}}, carry_in};
    assign hi        = sum >> w;
    assign low       = sum[WIDTH-1:0] & mask;
    assign carry_out = hi[WIDTH-1:0];

endmodule

// ===== hdl/mwsm_cell.sv =====
// One cell of the multiplier row: holds one A word, one B word and one
// product word, and trades them with its neighbors. Depends on mwsm_pkg.
module mwsm_cell
    import mwsm_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic           clk,
    input  mwsm_cell_ctl_t ctl,
    input  logic           is_tail,   // cell t-1
    input  logic           is_pre,    // cell t-2
    input  logic [WIDTH-1:0] a_nb,    // from the cell above (or load word)
    input  logic [WIDTH-1:0] b_nb,
    input  logic [WIDTH-1:0] b_head,  // cell 0, for the B ring wrap
    input  logic [WIDTH-1:0] p_nb1,   // cell k+1
    input  logic [WIDTH-1:0] p_nb2,   // cell k+2
    input  logic [WIDTH-1:0] p_lo,    // cell k-1
    input  logic [WIDTH-1:0] low,
    input  logic [WIDTH-1:0] carry,
    output logic [WIDTH-1:0] a_q,
    output logic [WIDTH-1:0] b_q,
    output logic [WIDTH-1:0] p_q
);

    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] p_reg, p_next;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        p_next = p_reg;
        if (ctl.load)
        begin
            a_next = a_nb;
            b_next = b_nb;
            p_next = '0;
        end
        else if (ctl.mac)
        begin
            b_next = is_tail ? b_head : b_nb;
            if (ctl.last)
            begin
                // row end: A advances; window drops two slots and
                // takes the final low word and the carry at the tail
                a_next = a_nb;
                p_next = is_tail ? carry : (is_pre ? low : p_nb2);
            end
            else
            begin
                p_next = is_tail ? low : p_nb1;
            end
        end
        else if (ctl.shr)
        begin
            p_next = p_lo;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign a_q = a_reg;
    assign b_q = b_reg;
    assign p_q = p_reg;

endmodule

// ===== hdl/mwsm_stack_cell.sv =====
// One cell of the low-word stack: finished low product words are pushed
// in ascending order and popped most significant first. Depends on mwsm_pkg.
module mwsm_stack_cell
    import mwsm_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  mwsm_stack_ctl_t  ctl,
    input  logic [WIDTH-1:0] d_up,   // cell k-1, or the pushed word
    input  logic [WIDTH-1:0] d_dn,   // cell k+1
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] d_reg, d_next;

    always_comb
    begin
        d_next = d_reg;
        if (ctl.push)
        begin
            d_next = d_up;
        end
        else if (ctl.pop)
        begin
            d_next = d_dn;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign q = d_reg;

endmodule

// ===== hdl/mwsm_checker.sv =====
// Port-level checker for the multiword schoolbook multiplier, bound to
// the top level below. Depends on mwsm_pkg.
module mwsm_checker
    import mwsm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // one item at a time: busy right after an input item is taken
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous item in progress");

    // tlast marks exactly the word with index zero
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[OUT_INDEX_W-1:0] == '0)))
        else $error("tlast does not match word index zero");

    // no new input while a product still has words to come
    a_no_in_mid_product: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready before the product was fully sent");

endmodule

bind multiword_schoolbook_multiplier_core mwsm_checker u_mwsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/multiword_schoolbook_multiplier_core_test.sv =====
// Self-checking testbench for multiword_schoolbook_multiplier_core: streams operand
// pairs under random idling, predicts every product word and compares in order.
// Depends on mwsm_pkg and the core RTL only.
module multiword_schoolbook_multiplier_core_test
    import mwsm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OPERAND_W-1:0] OPERAND_MAX   = '1;
    localparam logic [OPERAND_W-1:0] ALT_ONES      = 63'h5555_5555_5555_5555;
    localparam logic [OPERAND_W-1:0] ALT_TWOS      = 63'h2AAA_AAAA_AAAA_AAAA;
    localparam int                   WORD_LIMIT    = 16;
    localparam int                   RANDOM_ITEMS  = 380;
    localparam int                   SETTLE_CYCLES = 320;
    localparam int                   CYCLE_LIMIT   = 4_000_000;

    typedef struct {
        logic [OUT_INDEX_W-1:0] index;
        logic [OUT_VALUE_W-1:0] value;
        logic                   last;
    } product_word_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // operand_a[62:0], operand_b[125:63]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // word_index[4:0], word_value[36:5]
    logic                   m_tlast;          // last_word
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic [WBITS_W-1:0]     cur_word_bits = WORD_BITS_RST;
    logic [OPERAND_W-1:0]   cur_modulus   = MODULUS_RST;

    logic [S_TDATA_W-1:0]   operand_q[$];
    product_word_t          product_q[$];

    int error_count   = 0;
    int pairs_sent    = 0;
    int words_checked = 0;
    int settings_used = 1;
    int cycle_count   = 0;
    int tx_gap        = 0;
    int tx_quiet      = 0;
    int rx_stall      = 0;
    int rx_quiet      = 0;

    multiword_schoolbook_multiplier_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, product_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Operand-scanning schoolbook product of the current setting, queued MSW first.
    function automatic void predict_product(input logic [OPERAND_W-1:0] a,
                                            input logic [OPERAND_W-1:0] b);
        int unsigned          w;
        int unsigned          m;
        int unsigned          t;
        int unsigned          off;
        logic [63:0]          mask;
        logic [63:0]          s;
        logic [63:0]          carry;
        logic [OPERAND_W-1:0] span;
        logic [31:0]          aw[WORD_LIMIT];
        logic [31:0]          bw[WORD_LIMIT];
        logic [31:0]          pw[2*WORD_LIMIT];
        product_word_t        pword;
        w = cur_word_bits;
        if (w < W_MIN)
            w = W_MIN;
        if (w > 32)
            w = 32;
        mask = (w >= 32) ? 64'hFFFF_FFFF : ((64'd1 << w) - 64'd1);
        m = 0;
        if (cur_modulus != '0)
        begin
            span = cur_modulus - 1'b1;
            while (span != '0)
            begin
                m++;
                span = span >> 1;
            end
        end
        t = (m + w - 1) / w;
        if (t < 1)
            t = 1;
        if (t > WORD_LIMIT)
            t = WORD_LIMIT;
        for (int i = 0; i < t; i++)
        begin
            off = i * w;
            aw[i] = (off >= 64) ? 32'd0 : 32'(({1'b0, a} >> off) & mask);
            bw[i] = (off >= 64) ? 32'd0 : 32'(({1'b0, b} >> off) & mask);
        end
        for (int i = 0; i < 2 * WORD_LIMIT; i++)
            pw[i] = '0;
        for (int i = 0; i < t; i++)
        begin
            carry = '0;
            for (int j = 0; j < t; j++)
            begin
                // fits 64 bits: (2^32-1)^2 + 2*(2^32-1) = 2^64-1
                s = 64'(pw[i+j]) + 64'(aw[i]) * 64'(bw[j]) + carry;
                pw[i+j] = 32'(s & mask);
                carry = (s >> w) & mask;
            end
            pw[i+t] = 32'(carry);
        end
        for (int k = 2 * t - 1; k >= 0; k--)
        begin
            pword.index = OUT_INDEX_W'(k);
            pword.value = pw[k];
            pword.last  = (k == 0);
            product_q.push_back(pword);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OPERAND_W-1:0] rand_operand();
        logic [63:0] r;
        int unsigned len;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return OPERAND_MAX;
            2: return OPERAND_W'(1) << $urandom_range(0, OPERAND_W - 1);
            3, 4:
            begin
                len = $urandom_range(1, OPERAND_W);
                return r[OPERAND_W-1:0] & (OPERAND_MAX >> (OPERAND_W - len));
            end
            default: return r[OPERAND_W-1:0];
        endcase
    endfunction

    function automatic logic [OPERAND_W-1:0] rand_modulus();
        logic [63:0] r;
        int unsigned len;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return OPERAND_W'($urandom_range(0, 3));
            1: return OPERAND_MAX;
            2: return OPERAND_W'(1) << $urandom_range(1, OPERAND_W - 1);
            3: return (OPERAND_W'(1) << $urandom_range(1, OPERAND_W - 2)) + 1'b1;
            default:
            begin
                len = $urandom_range(2, OPERAND_W);
                return (r[OPERAND_W-1:0] & (OPERAND_MAX >> (OPERAND_W - len)))
                       | (OPERAND_W'(1) << (len - 1));
            end
        endcase
    endfunction

    function automatic logic [WBITS_W-1:0] rand_word_bits();
        case ($urandom_range(0, 9))
            0: return WBITS_W'($urandom_range(0, W_MIN - 1));
            1: return WBITS_W'($urandom_range(33, 63));
            2: return WBITS_W'(W_MIN);
            3: return WBITS_W'(32);
            default: return WBITS_W'($urandom_range(W_MIN, 32));
        endcase
    endfunction

    task automatic queue_pair(input logic [OPERAND_W-1:0] a, input logic [OPERAND_W-1:0] b);
        operand_q.push_back({2'b00, b, a});
    endtask

    task automatic wait_drain();
        do
            @(negedge clk);
        while (operand_q.size() != 0 || s_tvalid || product_q.size() != 0);
    endtask

    // Registers change only with the core idle; the upper data bits of the word-width write carry junk.
    task automatic set_config(input logic [WBITS_W-1:0] wbits,
                              input logic [OPERAND_W-1:0] modv);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        wait_drain();
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WORD_BITS;
        cfg_data  <= {junk[CFG_DATA_W-WBITS_W-1:0], wbits};
        @(posedge clk);
        cfg_index <= REG_MODULUS;
        cfg_data  <= modv;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_word_bits = wbits;
        cur_modulus   = modv;
        settings_used++;
    endtask

    // Driver: holds tvalid until taken, then idles for a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_product(s_tdata[OPERAND_W-1:0], s_tdata[2*OPERAND_W-1:OPERAND_W]);
                pairs_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (operand_q.size() != 0)
                begin
                    s_tdata  <= operand_q.pop_front();
                    s_tvalid <= 1'b1;
                    if (tx_quiet > 0)
                    begin
                        tx_quiet--;
                    end
                    else
                    begin
                        tx_gap = pick_gap();
                        if ($urandom_range(0, 39) == 0)
                            tx_quiet = $urandom_range(8, 40);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, in-order compare against predicted words.
    always @(posedge clk or negedge rst_n)
    begin
        product_word_t pword;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (product_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word, tdata %h tlast %b",
                                              m_tdata, m_tlast));
                end
                else
                begin
                    pword = product_q.pop_front();
                    words_checked++;
                    if (m_tdata[OUT_INDEX_W-1:0] !== pword.index)
                        report_mismatch($sformatf("index got %0d want %0d",
                                                  m_tdata[OUT_INDEX_W-1:0], pword.index));
                    if (m_tdata[OUT_INDEX_W+OUT_VALUE_W-1:OUT_INDEX_W] !== pword.value)
                        report_mismatch($sformatf("word %0d value got %h want %h", pword.index,
                                        m_tdata[OUT_INDEX_W+OUT_VALUE_W-1:OUT_INDEX_W],
                                        pword.value));
                    if (m_tlast !== pword.last)
                        report_mismatch($sformatf("word %0d tlast got %b want %b",
                                                  pword.index, m_tlast, pword.last));
                end
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rx_quiet > 0)
                begin
                    rx_quiet--;
                end
                else
                begin
                    if ($urandom_range(0, 2) == 0)
                        rx_stall = pick_gap();
                    if ($urandom_range(0, 39) == 0)
                        rx_quiet = $urandom_range(8, 40);
                end
            end
        end
    end

    initial
    begin
        int phase_no;
        int n;
        int random_sent;
        phase_no    = 0;
        random_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: w = 8, full-length modulus, t = 8
        queue_pair('0, '0);
        queue_pair(OPERAND_MAX, OPERAND_MAX);
        queue_pair(OPERAND_MAX, 63'd1);
        queue_pair(ALT_ONES, ALT_TWOS);
        // narrowest words, widest product (t = 16)
        set_config(WBITS_W'(4), OPERAND_MAX);
        queue_pair(OPERAND_MAX, OPERAND_MAX);
        queue_pair(ALT_ONES, OPERAND_MAX);
        queue_pair(63'd1, '0);
        // widest words, t = 2
        set_config(WBITS_W'(32), OPERAND_MAX);
        queue_pair(OPERAND_MAX, OPERAND_MAX);
        queue_pair('0, OPERAND_MAX);
        queue_pair(ALT_TWOS, ALT_ONES);
        // word width below range clamps up; modulus 2 gives one word
        set_config(WBITS_W'(0), 63'd2);
        queue_pair(OPERAND_MAX, OPERAND_MAX);
        queue_pair(63'd15, 63'd15);
        // word width above range clamps down; tiny modulus
        set_config(WBITS_W'(63), 63'd1);
        queue_pair(OPERAND_MAX, OPERAND_MAX);
        queue_pair(63'hFFFF_FFFF, 63'd2);
        set_config(WBITS_W'(9), '0);
        queue_pair(OPERAND_MAX, 63'd3);
        // uneven split, operand truncated above t*w bits
        set_config(WBITS_W'(13), 63'd1 << 40);
        queue_pair(OPERAND_MAX, ALT_ONES);
        queue_pair(ALT_TWOS, OPERAND_MAX);
        set_config(WBITS_W'(33), (63'd1 << 32) + 1'b1);
        queue_pair(OPERAND_MAX, OPERAND_MAX);

        while (random_sent < RANDOM_ITEMS)
        begin
            set_config(rand_word_bits(), rand_modulus());
            n = $urandom_range(20, 40);
            for (int k = 0; k < n; k++)
            begin
                // one mid-phase hold-off until the core has fully drained
                if (phase_no == 0 && k == n / 2)
                    wait_drain();
                queue_pair(rand_operand(), rand_operand());
            end
            random_sent += n;
            phase_no++;
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (product_q.size() != 0)
            report_mismatch($sformatf("%0d product words never arrived", product_q.size()));
        $display("Covered %0d operand pairs over %0d register settings,", pairs_sent,
                 settings_used);
        $display("%0d product words compared, %0d mismatches.", words_checked, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
